[rtl/cycle_counter_to_nanoseconds_top_macros.svh]
// Assertion macros for the cycle counter to nanoseconds block
`ifndef CYCLE_COUNTER_TO_NANOSECONDS_TOP_MACROS_SVH
`define CYCLE_COUNTER_TO_NANOSECONDS_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define CCN_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("%m: check failed");
`define CCN_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: check failed");
`else
`define CCN_ASSERT(label, clk, rst, prop)
`define CCN_ASSERT_NR(label, clk, prop)
`endif
`endif

[rtl/ccn_pkg.sv]
// Shared constants and types for the cycle counter to nanoseconds block
package ccn_pkg;

  localparam int SCALE_SHIFT = 5;
  localparam int CPU_COUNT   = 32;
  localparam int CPU_AW      = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;

  localparam int IN_W   = 136;
  localparam int OUT_W  = 64;
  localparam int CFG_W  = 20;
  localparam int FREQ_W = 14;
  localparam int SKEW_W = 20;
  localparam int CPU_W  = 5;

  localparam logic [63:0] NS_PER_SEC  = 64'd1000000000;
  localparam logic [63:0] HZ_PER_MHZ  = 64'd1000000;
  localparam logic [63:0] SCALE_NUM   = NS_PER_SEC << (32 - SCALE_SHIFT);
  localparam logic [FREQ_W-1:0] FREQ_RESET = 14'd1000;
  localparam logic [31:0] SCALE_RESET =
    32'(SCALE_NUM / (64'd1000 * HZ_PER_MHZ));

  localparam int DIV_STEPS = 64;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_READ = 2'd1,
    OP_SYNC = 2'd2,
    OP_RSVD = 2'd3
  } op_t;

  localparam logic [0:0] REG_CPU_FREQ = 1'b0;
  localparam logic [0:0] REG_MAX_SKEW = 1'b1;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

[rtl/ccn_mul.sv]
// Shared 32 by 32 multiplier with registered product
module ccn_mul
  import ccn_pkg::*;
(
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] prod
);

  always_ff @(posedge clk) begin
    prod <= 64'(a) * 64'(b);
  end

endmodule

[rtl/ccn_div.sv]
// Iterative restoring divider, one quotient bit per cycle
module ccn_div
  import ccn_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic [63:0] quotient,
  output div_stat_t   stat
);

  logic [63:0]       dvd;
  logic [63:0]       rem;
  logic [63:0]       dsr;
  logic [DIV_CW-1:0] cnt;
  logic              busy;
  logic              done;
  logic [64:0]       shifted;
  logic [64:0]       trial;

  assign shifted = {rem, dvd[63]};
  assign trial   = shifted - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CW'(DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      if (!trial[64]) begin
        rem <= trial[63:0];
        dvd <= {dvd[62:0], 1'b1};
      end else begin
        rem <= shifted[63:0];
        dvd <= {dvd[62:0], 1'b0};
      end
    end
  end

  assign quotient  = dvd;
  assign stat.busy = busy;
  assign stat.done = done;

endmodule

[rtl/ccn_skew.sv]
// Per-CPU skew store with valid bits and registered read
module ccn_skew
  import ccn_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [CPU_AW-1:0] rd_addr,
  output logic [63:0]       rd_data,
  input  logic              wr_en,
  input  logic [CPU_AW-1:0] wr_addr,
  input  logic [63:0]       wr_data
);

  logic [63:0]          mem [CPU_COUNT];
  logic [CPU_COUNT-1:0] valid;
  logic [63:0]          rd_q;
  logic                 rd_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

  assign rd_data = rd_valid ? rd_q : 64'd0;

endmodule

[rtl/cycle_counter_to_nanoseconds_top.sv]
// Top level: cycle count to nanosecond converter with tick calibration and skew table
//
// Input channel s_axis carries one item: a tick (opcode 0), a read (1) or a
// sync digest (2); opcode 3 is dropped. Output channel m_axis carries the
// signed nanosecond time, one item per read and none for tick or sync.
// The cfg port writes cpu_freq_mhz (index 0) and max_skew_cycles (index 1);
// a frequency write reloads the scale through the divider, and s_axis_tready
// is low meanwhile.
// Read and sync go from acceptance through prepare, two passes of the shared
// 32x32 multiplier, a sum and a finish state before ready again. A read's
// result enters the output register from the finish state.
// A tick after the first runs the radix-2 divider for 64 steps for the
// measured frequency and, unless that rate is zero, 64 more for the new
// scale; the first tick skips the divider.
// When the receiver stalls, the finished read waits in the output register and
// the next item is still accepted; a second read that finishes before the
// first is taken holds in the finish cycle and s_axis_tready stays low.
// Synchronous reset clears the time base, counters and skew valid bits, and
// loads the scale for 1000 MHz.
`include "cycle_counter_to_nanoseconds_top_macros.svh"
module cycle_counter_to_nanoseconds_top
  import ccn_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // opcode[1:0], cycle_count[65:2], slave_count[129:66], cpu_index[134:130]
  input  logic [IN_W-1:0]         s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // time_ns[63:0]
  output logic signed [OUT_W-1:0] m_axis_tdata,
  input  logic                    cfg_we,
  input  logic [0:0]              cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PREP  = 8'b0000_0010,
    S_MHI   = 8'b0000_0100,
    S_MLO   = 8'b0000_1000,
    S_SUM   = 8'b0001_0000,
    S_DONE  = 8'b0010_0000,
    S_DIVHZ = 8'b0100_0000,
    S_DIVSC = 8'b1000_0000
  } state_t;

  state_t             state;
  state_t             state_next;
  logic [1:0]         op_q;
  logic [63:0]        now_q;
  logic [63:0]        slave_q;
  logic [CPU_W-1:0]   cpu_q;
  logic [63:0]        x_q;
  logic               neg_q;
  logic               rec_q;
  logic [63:0]        acc;
  logic [63:0]        base_ns;
  logic [63:0]        last_count;
  logic [63:0]        first_count;
  logic [63:0]        seconds_seen;
  logic [31:0]        scale_factor;
  logic [FREQ_W-1:0]  cpu_freq_mhz;
  logic [SKEW_W-1:0]  max_skew_cycles;
  logic               reload_pending;

  logic               in_fire;
  logic               out_load;
  logic               range_ok;
  logic [63:0]        ds;
  logic [63:0]        dm;
  logic               ds_hit;
  logic               dm_hit;
  logic [31:0]        mul_a;
  logic [63:0]        prod;
  logic [63:0]        skew_rd;
  logic               skew_we;
  logic [63:0]        skew_wd;
  logic               div_start;
  logic [63:0]        div_dividend;
  logic [63:0]        div_divisor;
  logic [63:0]        quotient;
  div_stat_t          div_stat;

  assign s_axis_tready = (state == S_IDLE) && !reload_pending;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign range_ok      = 32'(cpu_q) < CPU_COUNT;

  assign ds     = slave_q - now_q;
  assign dm     = now_q - slave_q;
  assign ds_hit = !ds[63] && (ds > 64'(max_skew_cycles));
  assign dm_hit = !dm[63] && (dm > 64'(max_skew_cycles));

  assign mul_a = (state == S_MHI) ? x_q[63:32] : x_q[31:0];

  assign out_load = (state == S_DONE) && (op_q == OP_READ) &&
                    (!m_axis_tvalid || m_axis_tready);
  assign skew_we  = (state == S_DONE) && (op_q == OP_SYNC) && rec_q && range_ok;
  assign skew_wd  = neg_q ? (64'd0 - acc) : acc;

  ccn_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (scale_factor),
    .prod (prod)
  );

  ccn_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (quotient),
    .stat     (div_stat)
  );

  ccn_skew u_skew (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (CPU_AW'(cpu_q)),
    .rd_data (skew_rd),
    .wr_en   (skew_we),
    .wr_addr (CPU_AW'(cpu_q)),
    .wr_data (skew_wd)
  );

  always_comb begin
    state_next   = state;
    div_start    = 1'b0;
    div_dividend = SCALE_NUM;
    div_divisor  = 64'(cpu_freq_mhz) * HZ_PER_MHZ;
    case (state)
      S_IDLE: begin
        if (reload_pending) begin
          div_start  = 1'b1;
          state_next = S_DIVSC;
        end else if (in_fire && s_axis_tdata[1:0] != OP_RSVD) begin
          state_next = S_PREP;
        end
      end
      S_PREP:  state_next = S_MHI;
      S_MHI:   state_next = S_MLO;
      S_MLO:   state_next = S_SUM;
      S_SUM:   state_next = S_DONE;
      S_DONE: begin
        case (op_q)
          OP_READ: begin
            if (out_load) begin
              state_next = S_IDLE;
            end
          end
          OP_TICK: begin
            if (seconds_seen != 64'd0) begin
              div_start    = 1'b1;
              div_dividend = now_q - first_count;
              div_divisor  = seconds_seen;
              state_next   = S_DIVHZ;
            end else begin
              state_next = S_IDLE;
            end
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_DIVHZ: begin
        if (div_stat.done) begin
          if (quotient != 64'd0) begin
            div_start   = 1'b1;
            div_divisor = quotient;
            state_next  = S_DIVSC;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_DIVSC: begin
        if (div_stat.done) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      m_axis_tvalid   <= 1'b0;
      base_ns         <= '0;
      last_count      <= '0;
      first_count     <= '0;
      seconds_seen    <= '0;
      scale_factor    <= SCALE_RESET;
      cpu_freq_mhz    <= FREQ_RESET;
      max_skew_cycles <= '0;
      reload_pending  <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      if (state == S_IDLE && reload_pending) begin
        reload_pending <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_CPU_FREQ: begin
            cpu_freq_mhz   <= cfg_data[FREQ_W-1:0];
            reload_pending <= 1'b1;
          end
          REG_MAX_SKEW: max_skew_cycles <= cfg_data[SKEW_W-1:0];
          default: ;
        endcase
      end
      if (state == S_DONE && op_q == OP_TICK) begin
        base_ns      <= acc;
        last_count   <= now_q;
        seconds_seen <= seconds_seen + 64'd1;
        if (seconds_seen == 64'd0) begin
          first_count <= now_q;
        end
      end
      if (state == S_DIVSC && div_stat.done) begin
        scale_factor <= (quotient[63:32] != 32'd0) ? 32'hFFFF_FFFF : quotient[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q    <= s_axis_tdata[1:0];
      now_q   <= s_axis_tdata[65:2];
      slave_q <= s_axis_tdata[129:66];
      cpu_q   <= s_axis_tdata[134:130];
    end
    if (state == S_PREP) begin
      if (op_q == OP_SYNC) begin
        x_q   <= ds_hit ? ds : dm;
        neg_q <= ds_hit;
        rec_q <= ds_hit || dm_hit;
      end else begin
        x_q   <= now_q - last_count;
        neg_q <= 1'b0;
        rec_q <= 1'b0;
      end
    end
    if (state == S_MLO) begin
      acc <= ((op_q == OP_SYNC) ? 64'd0 : base_ns) + (prod << SCALE_SHIFT);
    end
    if (state == S_SUM) begin
      acc <= acc + (prod >> (32 - SCALE_SHIFT));
    end
    if (out_load) begin
      m_axis_tdata <= $signed(acc + (range_ok ? skew_rd : 64'd0));
    end
  end

  `CCN_ASSERT_NR(a_div_blocks_input, clk, (!rst && div_stat.busy) |-> !s_axis_tready)
  `CCN_ASSERT(a_out_from_read, clk, rst,
    $rose(m_axis_tvalid) |-> ($past(state) == S_DONE && $past(op_q) == OP_READ))
  `CCN_ASSERT(a_scale_from_div, clk, rst,
    (!$past(rst) && scale_factor != $past(scale_factor)) |-> $past(state) == S_DIVSC)

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// Testbench for the cycle counter to nanoseconds block: directed and random items
module tb_top
  import ccn_pkg::*;
();

  localparam int          QUIET_LIMIT = 4000;
  localparam int          IDLE_PAUSE  = 200;
  localparam int          HOLD_CYCLES = 300;
  localparam logic [63:0] NS_SCALED   = 64'd1000000000 << (32 - SCALE_SHIFT);
  localparam logic [63:0] HZ_PER_MHZ_C = 64'd1000000;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  // opcode[1:0], cycle_count[65:2], slave_count[129:66], cpu_index[134:130]
  logic [IN_W-1:0]         s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  // time_ns[63:0]
  logic signed [OUT_W-1:0] m_axis_tdata;
  logic                    cfg_we = 1'b0;
  logic [0:0]              cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;

  cycle_counter_to_nanoseconds_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #2 clk = ~clk;

  // time base state mirrored from the block
  logic [FREQ_W-1:0] freq_mhz;
  logic [SKEW_W-1:0] skew_limit;
  logic [63:0]       last_cnt;
  logic [63:0]       first_cnt;
  logic [63:0]       secs_seen;
  logic [63:0]       base_ns;
  logic [31:0]       scale;
  logic [63:0]       skew_ns [CPU_COUNT];

  logic [63:0] time_ns_q[$];
  int          mismatches = 0;
  int          quiet_cycles = 0;
  bit          gaps_on = 1'b1;
  bit          stall_on = 1'b1;
  bit          hold_req = 1'b0;
  logic [63:0] tick_hz = 64'd1000000000;

  function automatic logic [31:0] scale_for_hz(input logic [63:0] hz);
    logic [63:0] q;
    if (hz == 64'd0) return 32'hFFFF_FFFF;
    q = NS_SCALED / hz;
    if (q[63:32] != 32'd0) return 32'hFFFF_FFFF;
    return q[31:0];
  endfunction

  function automatic logic [63:0] cycles_to_ns(input logic [63:0] x);
    logic [63:0] hi_p;
    logic [63:0] lo_p;
    hi_p = {32'd0, x[63:32]} * {32'd0, scale};
    lo_p = {32'd0, x[31:0]} * {32'd0, scale};
    return (hi_p << SCALE_SHIFT) + (lo_p >> (32 - SCALE_SHIFT));
  endfunction

  function automatic void reset_model();
    freq_mhz   = FREQ_W'(1000);
    skew_limit = '0;
    last_cnt   = '0;
    first_cnt  = '0;
    secs_seen  = '0;
    base_ns    = '0;
    foreach (skew_ns[i]) skew_ns[i] = '0;
    scale = scale_for_hz(64'd1000 * HZ_PER_MHZ_C);
  endfunction

  function automatic void predict_time_ns(input logic [IN_W-1:0] d);
    logic [1:0]       op;
    logic [63:0]      now;
    logic [63:0]      slv;
    logic [CPU_W-1:0] cpu;
    logic [63:0]      ds;
    logic [63:0]      dm;
    logic [63:0]      hz;
    logic [63:0]      t;
    op  = d[1:0];
    now = d[65:2];
    slv = d[129:66];
    cpu = d[134:130];
    case (op)
      OP_TICK: begin
        base_ns  = base_ns + cycles_to_ns(now - last_cnt);
        last_cnt = now;
        if (secs_seen == 64'd0) begin
          first_cnt = now;
        end else begin
          hz = (now - first_cnt) / secs_seen;
          if (hz != 64'd0) scale = scale_for_hz(hz);
        end
        secs_seen = secs_seen + 64'd1;
      end
      OP_READ: begin
        t = base_ns + cycles_to_ns(now - last_cnt);
        if (int'(cpu) < CPU_COUNT) t = t + skew_ns[cpu];
        time_ns_q.push_back(t);
      end
      OP_SYNC: begin
        ds = slv - now;
        dm = now - slv;
        if (int'(cpu) < CPU_COUNT) begin
          if (!ds[63] && ds > {44'd0, skew_limit}) skew_ns[cpu] = 64'd0 - cycles_to_ns(ds);
          else if (!dm[63] && dm > {44'd0, skew_limit}) skew_ns[cpu] = cycles_to_ns(dm);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [IN_W-1:0] pack_item(input logic [1:0] op, input logic [63:0] cnt,
                                                input logic [63:0] slv,
                                                input logic [CPU_W-1:0] cpu);
    return {1'b0, cpu, slv, cnt, op};
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [IN_W-1:0] make_random_item();
    logic [63:0]      a;
    logic [63:0]      b;
    logic [63:0]      d;
    logic [63:0]      e;
    logic [63:0]      master;
    logic [CPU_W-1:0] cpu;
    int               sel;
    sel = $urandom_range(0, 99);
    cpu = CPU_W'($urandom_range(0, 31));
    a   = rand64();
    b   = rand64();
    d   = a >> $urandom_range(20, 63);
    if (sel < 55) return pack_item(OP_READ, last_cnt + d, b, cpu);
    if (sel < 70) begin
      master = last_cnt + (d >> 8);
      e = b >> $urandom_range(40, 63);
      if ($urandom_range(0, 7) == 0) e = {44'd0, skew_limit} + 64'($urandom_range(0, 1));
      return pack_item(OP_SYNC, master, b[0] ? master + e : master - e, cpu);
    end
    if (sel < 80) begin
      e = b >> $urandom_range(40, 63);
      return pack_item(OP_TICK, last_cnt + tick_hz + (b[1] ? e : 64'd0 - e), a, cpu);
    end
    return pack_item(2'($urandom_range(0, 3)), a, b, cpu);
  endfunction

  task automatic push_item(input logic [IN_W-1:0] d);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    predict_time_ns(d);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (time_ns_q.size() != 0) @(posedge clk);
    repeat (IDLE_PAUSE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [0:0] idx, input logic [CFG_W-1:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_CPU_FREQ) begin
      freq_mhz = val[FREQ_W-1:0];
      scale = scale_for_hz({50'd0, freq_mhz} * HZ_PER_MHZ_C);
    end else begin
      skew_limit = val[SKEW_W-1:0];
    end
  endtask

  task automatic test_reset_scale();
    push_item(pack_item(OP_READ, 64'd0, 64'd0, 5'd0));
    push_item(pack_item(OP_READ, '1, '1, 5'd31));
    push_item(pack_item(OP_RSVD, rand64(), rand64(), 5'd9));
    push_item(pack_item(OP_READ, 64'h0000_0001_FFFF_FFFF, 64'd0, 5'd5));
  endtask

  task automatic test_tick_calibration();
    push_item(pack_item(OP_TICK, 64'd1000, 64'd0, 5'd0));
    push_item(pack_item(OP_READ, 64'd1500, 64'd0, 5'd0));
    // same count again: measured rate zero, scale kept
    push_item(pack_item(OP_TICK, 64'd1000, 64'd0, 5'd0));
    // tiny rate: scale saturates
    push_item(pack_item(OP_TICK, 64'd1003, 64'd0, 5'd0));
    push_item(pack_item(OP_READ, 64'd1001003, 64'd0, 5'd1));
    push_item(pack_item(OP_TICK, 64'd3000001000, 64'd0, 5'd0));
    // huge rate: scale collapses to zero
    push_item(pack_item(OP_TICK, 64'hFFFF_FFFF_FFFF_FFF0, 64'd0, 5'd0));
    push_item(pack_item(OP_READ, 64'd12345, 64'd0, 5'd2));
    push_item(pack_item(OP_TICK, 64'd10000001000, 64'd0, 5'd0));
    push_item(pack_item(OP_READ, 64'd10500001000, 64'd0, 5'd0));
  endtask

  task automatic test_skew_sync();
    push_item(pack_item(OP_SYNC, 64'd1000, 64'd1500, 5'd3));
    push_item(pack_item(OP_SYNC, 64'd5000, 64'd100, 5'd4));
    push_item(pack_item(OP_SYNC, 64'd777, 64'd777, 5'd5));
    // both differences negative as signed values: nothing recorded
    push_item(pack_item(OP_SYNC, 64'd0, 64'h8000_0000_0000_0000, 5'd6));
    push_item(pack_item(OP_SYNC, 64'd0, 64'h7FFF_FFFF_FFFF_FFFF, 5'd7));
    cfg_write(REG_MAX_SKEW, 20'd1000);
    push_item(pack_item(OP_SYNC, 64'd2000, 64'd3000, 5'd3));
    push_item(pack_item(OP_SYNC, 64'd2000, 64'd999, 5'd4));
    push_item(pack_item(OP_READ, 64'd10500002000, 64'd0, 5'd3));
    push_item(pack_item(OP_READ, 64'd10500002000, 64'd0, 5'd4));
    push_item(pack_item(OP_READ, 64'd10500002000, 64'd0, 5'd6));
    push_item(pack_item(OP_READ, 64'd10500002000, 64'd0, 5'd7));
  endtask

  task automatic test_register_extremes();
    cfg_write(REG_CPU_FREQ, 20'd0);
    push_item(pack_item(OP_READ, last_cnt + 64'd4096, 64'd0, 5'd0));
    cfg_write(REG_CPU_FREQ, 20'd16383);
    push_item(pack_item(OP_READ, last_cnt + 64'd99999999, 64'd0, 5'd31));
    cfg_write(REG_MAX_SKEW, 20'hFFFFF);
    push_item(pack_item(OP_SYNC, 64'd0, 64'd1048575, 5'd8));
    push_item(pack_item(OP_SYNC, 64'd0, 64'd1048576, 5'd9));
    cfg_write(REG_CPU_FREQ, 20'd32);
    push_item(pack_item(OP_READ, last_cnt + 64'd32000000, 64'd0, 5'd8));
    push_item(pack_item(OP_READ, last_cnt + 64'd1, 64'd0, 5'd9));
  endtask

  task automatic test_random_traffic(input int n, input logic [FREQ_W-1:0] mhz,
                                     input logic [SKEW_W-1:0] lim, input logic [63:0] hz);
    logic [IN_W-1:0] d;
    int              sent;
    sent = 0;
    cfg_write(REG_CPU_FREQ, CFG_W'(mhz));
    cfg_write(REG_MAX_SKEW, CFG_W'(lim));
    tick_hz = hz;
    while (sent < n) begin
      d = make_random_item();
      if (d[1:0] != OP_RSVD) sent++;
      push_item(d);
    end
  endtask

  task automatic test_output_backpressure();
    drain();
    hold_req = 1'b1;
    gaps_on  = 1'b0;
    repeat (30) push_item(pack_item(OP_READ, last_cnt + 64'($urandom), rand64(),
                                    CPU_W'($urandom_range(0, 31))));
    gaps_on = 1'b1;
  endtask

  task automatic test_steady_stream();
    logic [IN_W-1:0] d;
    int              sent;
    sent = 0;
    drain();
    gaps_on  = 1'b0;
    stall_on = 1'b0;
    while (sent < 60) begin
      d = make_random_item();
      if (d[1:0] != OP_RSVD) sent++;
      push_item(d);
    end
  endtask

  initial begin
    logic [FREQ_W-1:0] mhz;
    reset_model();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_reset_scale();
    test_tick_calibration();
    test_skew_sync();
    test_register_extremes();
    test_random_traffic(180, FREQ_W'(0), 20'hFFFFF, 64'd1);
    test_random_traffic(180, FREQ_W'(16383), 20'd0, 64'd16383000000);
    test_random_traffic(180, FREQ_W'(32), SKEW_W'($urandom_range(0, 20'hFFFFF)), 64'd32000000);
    mhz = FREQ_W'($urandom_range(32, 10000));
    test_random_traffic(180, mhz, SKEW_W'($urandom_range(0, 4096)),
                        {50'd0, mhz} * HZ_PER_MHZ_C);
    test_output_backpressure();
    test_steady_stream();
    drain();
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // result side ready control
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (stall_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_time_ns
    logic [63:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (time_ns_q.size() == 0) begin
        $display("%0t: unexpected time_ns item, expected none, actual %0d",
                 $time, m_axis_tdata);
        mismatches++;
      end else begin
        want = time_ns_q.pop_front();
        if (want !== m_axis_tdata) begin
          $display("%0t: time_ns mismatch, expected %0d, actual %0d",
                   $time, $signed(want), m_axis_tdata);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

endmodule

[cycle_counter_to_nanoseconds_top.f]
+incdir+rtl
rtl/ccn_pkg.sv
rtl/ccn_mul.sv
rtl/ccn_div.sv
rtl/ccn_skew.sv
rtl/cycle_counter_to_nanoseconds_top.sv
tb/tb_top.sv
